/* rtl/uftt_pkg.sv */
`timescale 1ns / 1ps
package uftt_pkg;

	localparam int FLOW_ENTRIES = 64;
	localparam int TIME_BITS    = 48;
	localparam int IDX_W        = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
	localparam int TIMEOUT_W    = 32;
	localparam int CMP_W        = (TIME_BITS > TIMEOUT_W) ? TIME_BITS : TIMEOUT_W;
	localparam int KEY_W        = 96;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(10000);

	typedef struct packed {
		logic [31:0]          source_address;
		logic [31:0]          dest_address;
		logic [15:0]          source_port;
		logic [15:0]          dest_port;
		logic                 is_udp;
		logic                 forward_allowed;
		logic                 reverse_allowed;
		logic [TIME_BITS-1:0] now_ticks;
	} req_t;

	typedef struct packed {
		logic pass;
		logic flow_hit;
		logic flow_created;
		logic table_full;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
	} sts_t;

endpackage

/* rtl/uftt_datapath.sv */
`timescale 1ns / 1ps
module uftt_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  uftt_pkg::cmd_t                 cmd,
	output uftt_pkg::sts_t                 sts,
	input  uftt_pkg::req_t                 req,
	input  logic                           cfg_we,
	input  logic [uftt_pkg::TIMEOUT_W-1:0] cfg_wdata,
	output uftt_pkg::rsp_t                 rsp
);
	import uftt_pkg::*;

	logic [KEY_W-1:0]     key_mem [FLOW_ENTRIES];
	logic [TIME_BITS-1:0] ts_mem  [FLOW_ENTRIES];

	logic [FLOW_ENTRIES-1:0] valid_q;
	logic [TIMEOUT_W-1:0]    timeout_q;
	req_t                    req_q;
	rsp_t                    rsp_q;
	logic                    issue_q;
	logic [IDX_W-1:0]        cnt_q;
	logic                    vld_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic [KEY_W-1:0]        key_s1;
	logic [TIME_BITS-1:0]    ts_s1;
	logic                    hit_q;
	logic [IDX_W-1:0]        hit_idx_q;
	logic                    free_q;
	logic [IDX_W-1:0]        free_idx_q;

	logic [KEY_W-1:0]     key_f, key_r;
	logic [TIME_BITS-1:0] age;
	logic                 ent_v, aged, live, match;
	logic                 allow, insert;
	rsp_t                 result;

	assign key_f = {req_q.source_address, req_q.dest_address, req_q.source_port, req_q.dest_port};
	assign key_r = {req_q.dest_address, req_q.source_address, req_q.dest_port, req_q.source_port};

	assign ent_v = valid_q[idx_s1];
	assign age   = req_q.now_ticks - ts_s1;
	assign aged  = ent_v && (req_q.now_ticks >= ts_s1) &&
		(CMP_W'(age) >= CMP_W'(timeout_q));
	assign live  = ent_v && !aged;
	assign match = (key_s1 == key_f) || (key_s1 == key_r);

	assign allow  = req_q.forward_allowed && req_q.reverse_allowed;
	assign insert = req_q.is_udp && !hit_q && allow && free_q;

	always_comb begin
		result = '0;
		if (req_q.is_udp) begin
			if (hit_q) begin
				result.pass     = 1'b1;
				result.flow_hit = 1'b1;
			end else if (allow) begin
				result.pass         = 1'b1;
				result.flow_created = free_q;
				result.table_full   = !free_q;
			end
		end
	end

	assign sts.scan_done = !issue_q && !vld_s1;
	assign rsp = rsp_q;

	// entry store: read one entry per scan cycle, write on commit
	always_ff @(posedge clk) begin
		if (cmd.scan && issue_q) begin
			key_s1 <= key_mem[cnt_q];
			ts_s1  <= ts_mem[cnt_q];
		end
		if (cmd.commit && req_q.is_udp) begin
			if (hit_q) begin
				ts_mem[hit_idx_q] <= req_q.now_ticks;
			end else if (insert) begin
				key_mem[free_idx_q] <= key_f;
				ts_mem[free_idx_q]  <= req_q.now_ticks;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.commit) begin
			rsp_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			timeout_q  <= TIMEOUT_RESET;
			issue_q    <= 1'b0;
			cnt_q      <= '0;
			vld_s1     <= 1'b0;
			idx_s1     <= '0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (cmd.load) begin
				issue_q <= req.is_udp;
				cnt_q   <= '0;
				vld_s1  <= 1'b0;
				hit_q   <= 1'b0;
				free_q  <= 1'b0;
			end else if (cmd.scan) begin
				vld_s1 <= issue_q;
				idx_s1 <= cnt_q;
				if (issue_q) begin
					if (cnt_q == IDX_W'(FLOW_ENTRIES - 1)) begin
						issue_q <= 1'b0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				if (vld_s1) begin
					if (aged) begin
						valid_q[idx_s1] <= 1'b0;
					end
					if (live && match && !hit_q) begin
						hit_q     <= 1'b1;
						hit_idx_q <= idx_s1;
					end
					if (!live && !free_q) begin
						free_q     <= 1'b1;
						free_idx_q <= idx_s1;
					end
				end
			end
			if (cmd.commit && insert) begin
				valid_q[free_idx_q] <= 1'b1;
			end
		end
	end

endmodule

/* rtl/uftt_ctrl.sv */
`timescale 1ns / 1ps
module uftt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_is_udp,
	output logic           req_stall,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output uftt_pkg::cmd_t cmd,
	input  uftt_pkg::sts_t sts
);
	import uftt_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   slot_free;

	assign slot_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall  = (state_q != ST_IDLE);
	assign rsp_valid  = rsp_valid_q;
	assign cmd.load   = req_valid && (state_q == ST_IDLE);
	assign cmd.scan   = (state_q == ST_SCAN);
	assign cmd.commit = (state_q == ST_FINISH) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			// drop the response once taken, unless a new one replaces it
			if (rsp_valid_q && !rsp_stall && !cmd.commit) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= req_is_udp ? ST_SCAN : ST_FINISH;
					end
				end
				ST_SCAN: begin
					if (sts.scan_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (slot_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/udp_flow_tracking_table_core.sv */
`timescale 1ns / 1ps
// UDP flow tracking table core.
// Request channel: req_valid / req_stall with one packet descriptor in req.
// Response channel: rsp_valid / rsp_stall with one verdict in rsp.
// Config: cfg_we writes cfg_wdata into the flow timeout (ticks); write only
// while no request is in flight.
// Each UDP request walks all FLOW_ENTRIES entries through the single read
// port of the entry store, one entry per cycle; expiry, match and free-slot
// search happen in the same pass. A UDP request goes from acceptance through
// the scan state to the commit state; a non-UDP request goes straight to the
// commit state. One request is in flight at a time; req_stall is high while
// busy, so a new request is not taken before the last one is committed.
// The response sits in an output register: while the receiver stalls it is
// held, and a finished result waits before being written.
// Reset clears all valid bits (table empty) and loads a timeout of 10000;
// entry contents are left as is and only read behind a set valid bit.
module udp_flow_tracking_table_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  uftt_pkg::req_t                 req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output uftt_pkg::rsp_t                 rsp,
	input  logic                           cfg_we,
	input  logic [uftt_pkg::TIMEOUT_W-1:0] cfg_wdata
);
	import uftt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequence the request: accept, scan, commit
	uftt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_is_udp (req.is_udp),
		.req_stall  (req_stall),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.cmd        (cmd),
		.sts        (sts)
	);

	// entry store, valid bits, scan pipeline and verdict
	uftt_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rsp       (rsp)
	);

endmodule

/* rtl/uftt_checker.sv */
`timescale 1ns / 1ps
module uftt_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input uftt_pkg::rsp_t rsp
);
	import uftt_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while previous one in flight");

	a_deny_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.pass |-> !rsp.flow_hit && !rsp.flow_created && !rsp.table_full)
		else $error("denied response carries flags");

	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.pass |->
		$countones({rsp.flow_hit, rsp.flow_created, rsp.table_full}) == 1)
		else $error("passed response without exactly one outcome");

endmodule

bind udp_flow_tracking_table_core uftt_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
